[sv/dlle_pkg.sv]
// ----------------------------------------------------------------------------
// dlle_pkg
// Types and constants shared by the doubly linked list engine.
// ----------------------------------------------------------------------------
package dlle_pkg;

   localparam int unsigned DefCapacity   = 32;
   localparam int unsigned DefValueWidth = 32;
   localparam int unsigned OutLimit      = 32;

   typedef enum logic [3:0] {
      OP_INS_FRONT = 4'd0,
      OP_INS_BACK  = 4'd1,
      OP_INS_AT    = 4'd2,
      OP_DEL_FRONT = 4'd3,
      OP_DEL_BACK  = 4'd4,
      OP_DEL_AT    = 4'd5,
      OP_SEARCH    = 4'd6,
      OP_COUNT     = 4'd7,
      OP_LIST      = 4'd8
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_BAD_POS   = 3'd2,
      ST_FULL      = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   typedef struct packed {
      logic [3:0]         opcode;
      logic signed [31:0] item_value;
      logic [5:0]         position;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] result_value;
      logic [5:0]         node_total;
      logic               last_of_run;
   } rsp_type;

endpackage

[sv/doubly_linked_list_engine_top.sv]
// ----------------------------------------------------------------------------
// doubly_linked_list_engine_top
// Bounded doubly linked list kept in a node pool memory with a free map.
// ----------------------------------------------------------------------------
// One item at a time; the next item is taken once the engine is back in idle.
// Count goes from decode straight to the result. Front/back insert and
// front/back delete spend most of their time reading and rewriting the
// neighbor links (a read and then a write per neighbor). Positional insert
// and delete, search and list walk the links one node at a time through the
// single-port node memory, whose read is registered. A result that is still
// stalled holds the engine before it loads the next one. A list item returns
// one result per element, up to OutLimit, and the walk holds while the result
// register is stalled.
module doubly_linked_list_engine_top
   import dlle_pkg::*;
#(
   parameter int unsigned CAPACITY    = DefCapacity,
   parameter int unsigned VALUE_WIDTH = DefValueWidth
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int unsigned IW = $clog2(CAPACITY + 1);
   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam logic [IW-1:0] NIL = IW'(CAPACITY);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_DEC   = 8'b0000_0010,
      S_WALK  = 8'b0000_0100,
      S_WAIT  = 8'b0000_1000,
      S_LINK  = 8'b0001_0000,
      S_FIX   = 8'b0010_0000,
      S_EMIT  = 8'b0100_0000,
      S_LIST  = 8'b1000_0000
   } state_type;

   // node memory: {value, next, prev}
   localparam int unsigned NW = VALUE_WIDTH + 2 * IW;
   logic [NW-1:0] mem [CAPACITY];
   logic [NW-1:0] rd_ff;
   logic          mem_we;
   logic [AW-1:0] mem_addr;
   logic [NW-1:0] mem_wd;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wd;
      rd_ff <= mem[mem_addr];
   end

   wire [VALUE_WIDTH-1:0] rd_val  = rd_ff[NW-1 -: VALUE_WIDTH];
   wire [IW-1:0]          rd_next = rd_ff[2*IW-1 -: IW];
   wire [IW-1:0]          rd_prev = rd_ff[IW-1:0];

   state_type               state_ff, state_in;
   logic [CAPACITY-1:0]     free_ff, free_in;
   logic [IW-1:0]           head_ff, head_in, tail_ff, tail_in;
   logic [IW-1:0]           len_ff, len_in;
   req_type                 req_ff, req_in;
   logic [IW-1:0]           cur_ff, cur_in;     // node being walked / target
   logic [IW-1:0]           cnt_ff, cnt_in;     // walk step count
   logic [IW-1:0]           nn_ff, nn_in;       // fresh node
   logic [IW-1:0]           p_ff, p_in, x_ff, x_in;
   logic [VALUE_WIDTH-1:0]  v_ff, v_in;
   logic                    del_ff, del_in;
   logic [1:0]              fix_ff, fix_in;     // pending neighbor link writes
   status_type              st_ff, st_in;       // status of the item in work
   logic                    rv_ff, rv_in;
   rsp_type                 rsp_ff, rsp_in;

   // lowest free node
   logic [IW-1:0] free_idx;
   always_comb begin
      free_idx = NIL;
      for (int i = CAPACITY - 1; i >= 0; i--)
         if (free_ff[i]) free_idx = IW'(i);
   end

   wire [VALUE_WIDTH-1:0] req_v = VALUE_WIDTH'(signed'(req_ff.item_value));
   wire out_free = !rv_ff || !rsp_stall;

   function automatic logic [31:0] to32(input logic [VALUE_WIDTH-1:0] v);
      return 32'(signed'(v));
   endfunction

   always_comb begin
      state_in = state_ff; free_in = free_ff; head_in = head_ff; tail_in = tail_ff;
      len_in = len_ff; req_in = req_ff; cur_in = cur_ff; cnt_in = cnt_ff;
      nn_in = nn_ff; p_in = p_ff; x_in = x_ff; v_in = v_ff; del_in = del_ff;
      fix_in = fix_ff; st_in = st_ff; rv_in = rv_ff && rsp_stall; rsp_in = rsp_ff;
      mem_we = 1'b0; mem_addr = AW'(cur_ff); mem_wd = '0;
      req_stall = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: if (req_valid) begin
            req_in = req_data;
            state_in = S_DEC;
         end
         S_DEC: begin
            v_in = '0;
            st_in = ST_OK;
            unique case (req_ff.opcode)
               OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
                  del_in = 1'b0;
                  nn_in = free_idx;
                  if (len_ff >= NIL) begin
                     st_in = ST_FULL; state_in = S_EMIT;
                  end else if (req_ff.opcode == OP_INS_FRONT ||
                               (req_ff.opcode == OP_INS_AT && req_ff.position == 6'd1)) begin
                     p_in = NIL; x_in = head_ff; state_in = S_LINK;
                  end else if (req_ff.opcode == OP_INS_BACK ||
                               (req_ff.opcode == OP_INS_AT &&
                                7'(req_ff.position) == 7'(len_ff) + 7'd1)) begin
                     p_in = tail_ff; x_in = NIL; state_in = S_LINK;
                  end else if (req_ff.position == 6'd0 ||
                               7'(req_ff.position) > 7'(len_ff) + 7'd1) begin
                     st_in = ST_BAD_POS; state_in = S_EMIT;
                  end else begin
                     cur_in = head_ff; cnt_in = IW'(1); state_in = S_WALK;
                  end
               end
               OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
                  del_in = 1'b1;
                  if (len_ff == '0) begin
                     st_in = ST_EMPTY; state_in = S_EMIT;
                  end else if (req_ff.opcode == OP_DEL_AT &&
                               (req_ff.position == 6'd0 ||
                                7'(req_ff.position) > 7'(len_ff))) begin
                     st_in = ST_BAD_POS; state_in = S_EMIT;
                  end else begin
                     cur_in = (req_ff.opcode == OP_DEL_BACK) ? tail_ff : head_ff;
                     cnt_in = (req_ff.opcode == OP_DEL_AT) ? IW'(1) : IW'(req_ff.position);
                     if (req_ff.opcode != OP_DEL_AT) cnt_in = '0;
                     state_in = S_WALK;
                  end
               end
               OP_SEARCH: begin
                  cur_in = head_ff;
                  if (head_ff == NIL) begin
                     st_in = ST_NOT_FOUND; state_in = S_EMIT;
                  end else state_in = S_WALK;
               end
               OP_COUNT: state_in = S_EMIT;
               OP_LIST: begin
                  cur_in = head_ff; cnt_in = '0;
                  if (len_ff == '0) begin
                     st_in = ST_EMPTY; state_in = S_EMIT;
                  end else state_in = S_WALK;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_WALK: begin
            // issue read of cur
            mem_addr = AW'(cur_ff);
            state_in = S_WAIT;
         end
         S_WAIT: begin
            mem_addr = AW'(cur_ff);
            if (req_ff.opcode == OP_SEARCH) begin
               if (rd_val == req_v) begin
                  st_in = ST_OK; state_in = S_EMIT;
               end else if (rd_next == NIL) begin
                  st_in = ST_NOT_FOUND; state_in = S_EMIT;
               end else begin
                  cur_in = rd_next; state_in = S_WALK;
               end
            end else if (req_ff.opcode == OP_LIST) begin
               if (out_free) begin
                  rv_in = 1'b1;
                  rsp_in.status = ST_OK;
                  rsp_in.result_value = to32(rd_val);
                  rsp_in.node_total = 6'(len_ff);
                  rsp_in.last_of_run = (rd_next == NIL) || (cnt_ff == IW'(OutLimit - 1));
                  cnt_in = cnt_ff + 1'b1;
                  cur_in = rd_next;
                  state_in = rsp_in.last_of_run ? S_LIST : S_WALK;
               end
            end else if (cnt_ff != '0 && 7'(cnt_ff) != 7'(req_ff.position)) begin
               cur_in = rd_next; cnt_in = cnt_ff + 1'b1; state_in = S_WALK;
            end else if (del_ff) begin
               p_in = rd_prev; x_in = rd_next; v_in = rd_val;
               state_in = S_LINK;
            end else begin
               // insert before cur
               p_in = rd_prev; x_in = cur_ff; state_in = S_LINK;
            end
         end
         S_LINK: begin
            if (del_ff) begin
               free_in[AW'(cur_ff)] = 1'b1;
               len_in = len_ff - 1'b1;
               if (p_ff == NIL) head_in = x_ff;
               if (x_ff == NIL) tail_in = p_ff;
            end else begin
               mem_we = 1'b1; mem_addr = AW'(nn_ff);
               mem_wd = {req_v, x_ff, p_ff};
               free_in[AW'(nn_ff)] = 1'b0;
               len_in = len_ff + 1'b1;
               if (p_ff == NIL) head_in = nn_ff;
               if (x_ff == NIL) tail_in = nn_ff;
            end
            fix_in = {p_ff != NIL, x_ff != NIL};
            cur_in = p_ff;
            // start the neighbor fix with a read, never a write
            cnt_in = '0;
            state_in = S_FIX;
         end
         S_FIX: begin
            // read-modify-write of a neighbor: read, then write next cycle
            if (fix_ff[1]) begin
               mem_addr = AW'(p_ff);
               if (cur_ff == p_ff && cnt_ff == NIL) begin
                  mem_we = 1'b1;
                  mem_wd = {rd_val, del_ff ? x_ff : nn_ff, rd_prev};
                  fix_in[1] = 1'b0; cnt_in = '0;
               end else cnt_in = NIL;
               cur_in = p_ff;
            end else if (fix_ff[0]) begin
               mem_addr = AW'(x_ff);
               if (cnt_ff == NIL && cur_ff == x_ff) begin
                  mem_we = 1'b1;
                  mem_wd = {rd_val, rd_next, del_ff ? p_ff : nn_ff};
                  fix_in[0] = 1'b0; cnt_in = '0;
               end else cnt_in = NIL;
               cur_in = x_ff;
            end else state_in = S_EMIT;
         end
         S_EMIT: if (out_free) begin
            rv_in = 1'b1;
            rsp_in.status = st_ff;
            rsp_in.result_value = (st_ff == ST_OK) ? to32(v_ff) : 32'sd0;
            rsp_in.node_total = 6'(len_ff);
            rsp_in.last_of_run = 1'b1;
            state_in = S_IDLE;
         end
         S_LIST: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         free_ff  <= '1;
         head_ff  <= NIL;
         tail_ff  <= NIL;
         len_ff   <= '0;
         rv_ff    <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         free_ff  <= free_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         len_ff   <= len_in;
         rv_ff    <= rv_in;
         cnt_ff   <= cnt_in;
      end
      req_ff <= req_in; cur_ff <= cur_in; nn_ff <= nn_in; p_ff <= p_in;
      x_ff <= x_in; v_ff <= v_in; del_ff <= del_in; fix_ff <= fix_in;
      st_ff <= st_in; rsp_ff <= rsp_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= NIL) else $error("list length beyond capacity");
   a_empty_heads: assert property (@(posedge clock) disable iff (reset)
      (len_ff == '0) |-> (head_ff == NIL && tail_ff == NIL))
      else $error("empty list with live head or tail");
   a_free_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ($countones(free_ff) == CAPACITY - 32'(len_ff)))
      else $error("free map out of step with length");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall) else $error("item taken while busy");
`endif

endmodule
